FILE: src/assert_macros.svh
// Assertion helper macros shared by the digit entry buffer RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: src/cdeb_pkg.sv
// Shared types and constants for the calculator digit entry buffer.
// No dependencies.
package cdeb_pkg;

   localparam int DEF_DISPLAY_DIGITS = 8;

   // Binary to BCD conversion of a 16-bit magnitude
   localparam int BIN_W      = 16;
   localparam int BCD_DIGITS = 5;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int STEP_W     = $clog2(BIN_W);

   localparam logic [3:0] DIGIT_ZERO  = 4'd0;
   localparam logic [3:0] DIGIT_NINE  = 4'd9;
   localparam logic [3:0] DIGIT_BLANK = 4'd15;

   typedef logic [2:0] op_type;
   localparam op_type OP_APPEND = 3'd0;
   localparam op_type OP_DELETE = 3'd1;
   localparam op_type OP_CLEAR  = 3'd2;
   localparam op_type OP_SET    = 3'd3;
   localparam op_type OP_ERROR  = 3'd4;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_ENTRY  = 2'd0;
   localparam mode_type MODE_RESULT = 2'd1;
   localparam mode_type MODE_ERROR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_FINISH
   } state_type;

   // Status of the conversion unit
   typedef struct packed {
      logic busy;
      logic done;
   } conv_stat_type;

endpackage

FILE: src/cdeb_bcd_conv.sv
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on cdeb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdeb_bcd_conv (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cdeb_pkg::BIN_W-1:0]   magnitude,
   output cdeb_pkg::conv_stat_type      stat,
   output logic [cdeb_pkg::BCD_W-1:0]   bcd
);
   import cdeb_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [BCD_W-1:0]  bcd_adj;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   // sequencing of the sixteen shift steps
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = STEP_W'(BIN_W - 1);
         bin_in   = magnitude;
         bcd_in   = '0;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign bcd       = bcd_ff;

   `ASSERT_CLK_RST(a_conv_runs_out, clock, reset,
      (busy_ff && count_ff != '0 && !start) |=> busy_ff, "conversion stopped early")
   `ASSERT_NEVER(a_conv_done_idle, clock, reset, done_ff && busy_ff,
      "conversion done while still busy")
   `ASSERT_CLK_RST(a_conv_done_pulse, clock, reset, done_ff |=> !done_ff,
      "done held for more than one cycle")

endmodule

FILE: src/calculator_digit_entry_buffer_unit.sv
// Calculator digit entry buffer: right-aligned digit register with sign, length, mode.
// Set requests: ST_CONV for the 16 shift steps of the BCD unit, then ST_FINISH.
// Other requests go straight to ST_FINISH; commit waits there while a response is pending.
// One request at a time: req_ready is high only in ST_IDLE, which follows the commit.
// Synchronous active-high reset: rightmost digit 0, others blank, length 0, entry mode.
// Depends on cdeb_pkg, cdeb_bcd_conv and assert_macros.svh.
`include "assert_macros.svh"

module calculator_digit_entry_buffer_unit #(
   parameter int DISPLAY_DIGITS = cdeb_pkg::DEF_DISPLAY_DIGITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cdeb_pkg::op_type          req_opcode,
   input  logic [3:0]                req_key_digit,
   input  logic signed [15:0]        req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_flash,
   output cdeb_pkg::mode_type        rsp_mode,
   output logic                      rsp_negative,
   output logic [2:0]                rsp_entry_length,
   output logic [27:0]               rsp_digits_packed
);
   import cdeb_pkg::*;

   localparam int NPOS     = DISPLAY_DIGITS - 1;
   localparam int LEN_W    = $clog2(NPOS + 1);
   localparam int OUT_POS  = 7;

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [3:0]        key_ff;
   logic              value_neg_ff;
   logic [3:0]        digit_ff [NPOS];
   logic [3:0]        digit_in [NPOS];
   logic [3:0]        shift_up [NPOS];
   logic [3:0]        shift_down [NPOS];
   logic [3:0]        set_digit [NPOS];
   logic [LEN_W-1:0]  len_ff, len_in, len_dec;
   logic              sign_ff, sign_in;
   mode_type          mode_ff, mode_in;
   logic              flash_ff, flash_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept, slot_free, commit, conv_start;
   logic [BIN_W-1:0]  value_u, magnitude;
   conv_stat_type     conv_stat;
   logic [BCD_W-1:0]  conv_bcd;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign value_u   = req_value;
   assign magnitude = value_u[BIN_W-1] ? (~value_u + BIN_W'(1)) : value_u;

   cdeb_bcd_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .magnitude (magnitude),
      .stat      (conv_stat),
      .bcd       (conv_bcd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_opcode == OP_SET) ? ST_CONV : ST_FINISH;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      commit     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_CONV:   req_ready = 1'b0;
         ST_FINISH: commit    = slot_free;
         default:   req_ready = 1'b0;
      endcase
      conv_start = req_valid && req_ready && (req_opcode == OP_SET);
   end

   // shifted and converted views of the digit register
   for (genvar i = 0; i < NPOS; i++) begin : g_pos
      if (i == 0) begin : g_first
         assign shift_up[i]  = key_ff;
         assign set_digit[i] = conv_bcd[3:0];
      end else begin : g_rest
         assign shift_up[i] = digit_ff[i-1];
         if (i < BCD_DIGITS) begin : g_bcd
            assign set_digit[i] = (conv_bcd[BCD_W-1:4*i] != '0) ?
                                  conv_bcd[4*i +: 4] : DIGIT_BLANK;
         end else begin : g_blank
            assign set_digit[i] = DIGIT_BLANK;
         end
      end
      if (i < NPOS - 1) begin : g_down
         assign shift_down[i] = digit_ff[i+1];
      end else begin : g_top
         assign shift_down[i] = DIGIT_BLANK;
      end
   end

   assign len_dec = len_ff - LEN_W'(1);

   // operation applied at commit
   always_comb begin
      digit_in = digit_ff;
      len_in   = len_ff;
      sign_in  = sign_ff;
      mode_in  = mode_ff;
      flash_in = 1'b0;
      unique case (op_ff)
         OP_APPEND: begin
            if (len_ff >= LEN_W'(NPOS)) begin
               flash_in = 1'b1;
            end else if (key_ff <= DIGIT_NINE) begin
               mode_in = MODE_ENTRY;
               for (int i = 0; i < NPOS; i++) begin
                  if (LEN_W'(i) <= len_ff) begin
                     digit_in[i] = shift_up[i];
                  end
               end
               if (len_ff != '0 || key_ff != DIGIT_ZERO) begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
         end
         OP_DELETE: begin
            if (len_ff == '0) begin
               flash_in = 1'b1;
            end else begin
               len_in = len_dec;
               for (int i = 0; i < NPOS; i++) begin
                  if (LEN_W'(i) < len_dec) begin
                     digit_in[i] = shift_down[i];
                  end else if (LEN_W'(i) == len_dec) begin
                     digit_in[i] = DIGIT_BLANK;
                  end
               end
               if (len_dec == '0) begin
                  digit_in[0] = DIGIT_ZERO;
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < NPOS; i++) begin
               digit_in[i] = DIGIT_BLANK;
            end
            digit_in[0] = DIGIT_ZERO;
            len_in      = '0;
            sign_in     = 1'b0;
            mode_in     = MODE_ENTRY;
         end
         OP_SET: begin
            sign_in  = value_neg_ff;
            mode_in  = MODE_RESULT;
            digit_in = set_digit;
         end
         OP_ERROR: mode_in = MODE_ERROR;
         default: flash_in = 1'b0;
      endcase
   end

   // response valid: set on commit, dropped when taken
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flash_ff     <= 1'b0;
         len_ff       <= '0;
         sign_ff      <= 1'b0;
         mode_ff      <= MODE_ENTRY;
         for (int i = 0; i < NPOS; i++) begin
            digit_ff[i] <= (i == 0) ? DIGIT_ZERO : DIGIT_BLANK;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            flash_ff <= flash_in;
            len_ff   <= len_in;
            sign_ff  <= sign_in;
            mode_ff  <= mode_in;
            digit_ff <= digit_in;
         end
      end
      // request payload capture
      if (accept) begin
         op_ff        <= req_opcode;
         key_ff       <= req_key_digit;
         value_neg_ff <= value_u[BIN_W-1];
      end
   end

   // result ports come straight from the registers; all but rsp_valid only change at commit
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_flash        = flash_ff;
   assign rsp_mode         = mode_ff;
   assign rsp_negative     = sign_ff;
   assign rsp_entry_length = len_ff[2:0];

   for (genvar j = 0; j < OUT_POS; j++) begin : g_pack
      if (j < NPOS) begin : g_used
         assign rsp_digits_packed[4*j +: 4] = digit_ff[j];
      end else begin : g_unused
         assign rsp_digits_packed[4*j +: 4] = 4'h0;
      end
   end

   `ASSERT_NEVER(a_len_bound, clock, reset, len_ff > LEN_W'(NPOS),
      "entry length beyond register size")
   `ASSERT_CLK_RST(a_conv_in_state, clock, reset,
      conv_stat.busy |-> (state_ff == ST_CONV), "converter busy outside conversion")
   `ASSERT_CLK_RST(a_commit_resp, clock, reset,
      commit |=> rsp_valid_ff, "commit without response")
   `ASSERT_CLK_RST(a_hold_state, clock, reset,
      (rsp_valid_ff && !rsp_ready) |=> ($stable(len_ff) && $stable(mode_ff)),
      "state changed under a pending response")

endmodule

FILE: test/calculator_digit_entry_buffer_unit_tb.sv
// Self-checking testbench for the calculator digit entry buffer unit.
// A keystroke table and then random keypad traffic, scored against a behavioral display model.
// Depends on cdeb_pkg and calculator_digit_entry_buffer_unit.
`timescale 1ns / 1ps

module calculator_digit_entry_buffer_unit_tb;
   import cdeb_pkg::*;

   localparam int NPOS          = DEF_DISPLAY_DIGITS - 1;
   localparam int TABLE_ROWS    = 26;
   localparam int RANDOM_KEYS   = 950;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int LONG_HOLD     = 150;
   localparam int MAX_IDLE      = 12;

   // opcodes that the block leaves without effect
   localparam op_type OP_UNUSED_LO  = 3'd5;
   localparam op_type OP_UNUSED_MID = 3'd6;
   localparam op_type OP_UNUSED_HI  = 3'd7;

   // one response as the display shows it
   typedef struct packed {
      logic        flash;
      mode_type    mode;
      logic        negative;
      logic [2:0]  entry_length;
      logic [27:0] digits;
   } display_type;

   // one row of the keystroke table
   typedef struct {
      op_type      op;
      logic [3:0]  key;
      logic [15:0] val;
      bit          typed;
      display_type want;
   } keystroke_type;

   localparam display_type NO_CHECK = '0;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   op_type      req_opcode    = OP_APPEND;
   logic [3:0]  req_key_digit = 4'd0;
   logic [15:0] req_value     = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic        rsp_flash;
   mode_type    rsp_mode;
   logic        rsp_negative;
   logic [2:0]  rsp_entry_length;
   logic [27:0] rsp_digits_packed;

   // display model state
   logic [3:0] shown [NPOS];
   int         entered;
   logic       sign_q;
   mode_type   mode_q;

   display_type   pending_displays [$];
   keystroke_type script [TABLE_ROWS];

   int  mismatches;
   int  responses_checked;
   int  flashes_seen;
   int  requests_sent;
   int  op_seen [8];
   int  ready_hold;
   int  cycles;
   bit  burst;
   bit  long_hold_due;

   calculator_digit_entry_buffer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_key_digit     (req_key_digit),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_flash         (rsp_flash),
      .rsp_mode          (rsp_mode),
      .rsp_negative      (rsp_negative),
      .rsp_entry_length  (rsp_entry_length),
      .rsp_digits_packed (rsp_digits_packed)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   // display back to its power-up look
   function automatic void clear_display();
      for (int i = 0; i < NPOS; i++) shown[i] = DIGIT_BLANK;
      shown[0] = DIGIT_ZERO;
      entered  = 0;
      sign_q   = 1'b0;
      mode_q   = MODE_ENTRY;
   endfunction

   // apply one keypad request to the model, return what the display shows
   function automatic display_type next_display(input op_type op, input logic [3:0] key,
                                                input logic [15:0] val);
      display_type shows;
      int          mag;
      bit          past_top;
      shows = '0;
      case (op)
         OP_APPEND: begin
            if (entered >= NPOS) begin
               shows.flash = 1'b1;
            end else if (key <= DIGIT_NINE) begin
               mode_q = MODE_ENTRY;
               for (int i = entered - 1; i >= 0; i--) shown[i + 1] = shown[i];
               shown[0] = key;
               // a lone leading zero is not a digit of the entry
               if (entered != 0 || key != DIGIT_ZERO) entered++;
            end
         end
         OP_DELETE: begin
            if (entered == 0) begin
               shows.flash = 1'b1;
            end else begin
               entered--;
               for (int i = 0; i < entered; i++) shown[i] = shown[i + 1];
               shown[entered] = DIGIT_BLANK;
               if (entered == 0) shown[0] = DIGIT_ZERO;
            end
         end
         OP_CLEAR: clear_display();
         OP_SET: begin
            sign_q   = val[15];
            mag      = val[15] ? 65536 - int'(val) : int'(val);
            mode_q   = MODE_RESULT;
            past_top = 1'b0;
            for (int i = 0; i < NPOS; i++) begin
               shown[i] = past_top ? DIGIT_BLANK : 4'(mag % 10);
               mag      = mag / 10;
               if (mag == 0) past_top = 1'b1;
            end
         end
         OP_ERROR: mode_q = MODE_ERROR;
         default: ;
      endcase
      shows.mode         = mode_q;
      shows.negative     = sign_q;
      shows.entry_length = 3'(entered);
      for (int i = 0; i < NPOS; i++) shows.digits[4 * i +: 4] = shown[i];
      return shows;
   endfunction

   // offer one request, record its expected display once accepted
   task automatic offer(input op_type op, input logic [3:0] key, input logic [15:0] val,
                        input bit typed, input display_type want);
      display_type predicted;
      int          gap;
      gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode    <= op;
      req_key_digit <= key;
      req_value     <= val;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = next_display(op, key, val);
      pending_displays.push_back(typed ? want : predicted);
      op_seen[op]++;
      requests_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait until every expected response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_displays.size() != 0) @(posedge clock);
   endtask

   task automatic flag_field(input string field, input logic [27:0] want_v,
                             input logic [27:0] got_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      mismatches++;
   endtask

   // response ready: low while a hold is counting down
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // score each response against the oldest expected display
   always @(posedge clock) begin
      display_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_displays.size() == 0) begin
            $display("%0t: response with nothing expected, actual %h", $time,
                     {rsp_flash, rsp_mode, rsp_negative, rsp_entry_length, rsp_digits_packed});
            mismatches++;
         end else begin
            want = pending_displays.pop_front();
            responses_checked++;
            if (rsp_flash) flashes_seen++;
            if (rsp_flash !== want.flash)
               flag_field("flash", 28'(want.flash), 28'(rsp_flash));
            if (rsp_mode !== want.mode)
               flag_field("mode", 28'(want.mode), 28'(rsp_mode));
            if (rsp_negative !== want.negative)
               flag_field("negative", 28'(want.negative), 28'(rsp_negative));
            if (rsp_entry_length !== want.entry_length)
               flag_field("entry_length", 28'(want.entry_length), 28'(rsp_entry_length));
            if (rsp_digits_packed !== want.digits)
               flag_field("digits_packed", want.digits, rsp_digits_packed);
         end
         if (long_hold_due) begin
            ready_hold    = LONG_HOLD;
            long_hold_due = 1'b0;
         end else begin
            ready_hold = burst ? 0 : $urandom_range(0, MAX_IDLE);
         end
      end
   end

   initial begin
      op_type      op;
      logic [3:0]  key;
      logic [15:0] val;
      int          pick;

      // keystroke table: typed rows are read straight off the display rules
      script = '{
         '{OP_DELETE,    4'd0,  16'h0000, 1'b1, {1'b1, MODE_ENTRY,  1'b0, 3'd0, 28'hFFFFFF0}},
         '{OP_APPEND,    4'd0,  16'h0000, 1'b1, {1'b0, MODE_ENTRY,  1'b0, 3'd0, 28'hFFFFFF0}},
         '{OP_APPEND,    4'd9,  16'h0000, 1'b1, {1'b0, MODE_ENTRY,  1'b0, 3'd1, 28'hFFFFFF9}},
         '{OP_APPEND,    4'd0,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd8,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd7,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd6,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd5,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd4,  16'h0000, 1'b1, {1'b0, MODE_ENTRY,  1'b0, 3'd7, 28'h9087654}},
         '{OP_APPEND,    4'd3,  16'h0000, 1'b1, {1'b1, MODE_ENTRY,  1'b0, 3'd7, 28'h9087654}},
         '{OP_APPEND,    4'd15, 16'hFFFF, 1'b0, NO_CHECK},
         '{OP_DELETE,    4'd0,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd12, 16'h0000, 1'b0, NO_CHECK},
         '{OP_ERROR,     4'd0,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd1,  16'h0000, 1'b0, NO_CHECK},
         '{OP_UNUSED_LO, 4'd9,  16'h1234, 1'b0, NO_CHECK},
         '{OP_CLEAR,     4'd0,  16'h0000, 1'b1, {1'b0, MODE_ENTRY,  1'b0, 3'd0, 28'hFFFFFF0}},
         '{OP_SET,       4'd0,  16'h8000, 1'b1, {1'b0, MODE_RESULT, 1'b1, 3'd0, 28'hFF32768}},
         '{OP_SET,       4'd0,  16'h7FFF, 1'b1, {1'b0, MODE_RESULT, 1'b0, 3'd0, 28'hFF32767}},
         '{OP_SET,       4'd0,  16'h0000, 1'b1, {1'b0, MODE_RESULT, 1'b0, 3'd0, 28'hFFFFFF0}},
         '{OP_SET,       4'd0,  16'hFFFF, 1'b0, NO_CHECK},
         '{OP_DELETE,    4'd0,  16'h0000, 1'b0, NO_CHECK},
         '{OP_APPEND,    4'd5,  16'h0000, 1'b0, NO_CHECK},
         '{OP_UNUSED_HI, 4'd15, 16'hFFFF, 1'b0, NO_CHECK},
         '{OP_ERROR,     4'd0,  16'h0000, 1'b0, NO_CHECK},
         '{OP_DELETE,    4'd0,  16'h0000, 1'b0, NO_CHECK}
      };

      clear_display();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < TABLE_ROWS; r++)
         offer(script[r].op, script[r].key, script[r].val, script[r].typed, script[r].want);

      // random keypad traffic: mostly digit entry with edits, some results and noise
      for (int k = 0; k < RANDOM_KEYS; k++) begin
         burst = (k % 160) < 30;
         if (k == 300) long_hold_due = 1'b1;
         if (k == 600) begin
            wait_for_drain();
            @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         key  = 4'($urandom_range(0, 9));
         val  = 16'($urandom);
         if (pick < 45) begin
            op = OP_APPEND;
            if ($urandom_range(0, 9) == 0) key = 4'($urandom_range(10, 15));
         end else if (pick < 65) begin
            op = OP_DELETE;
         end else if (pick < 75) begin
            op = OP_SET;
            case ($urandom_range(0, 9))
               0: val = 16'h8000;
               1: val = 16'h7FFF;
               2: val = 16'h0000;
               3: val = 16'hFFFF;
               4: val = 16'($urandom_range(0, 999));
               5: val = -16'($urandom_range(0, 999));
               default: ;
            endcase
         end else if (pick < 82) begin
            op = OP_CLEAR;
         end else if (pick < 88) begin
            op = OP_ERROR;
         end else begin
            op = op_type'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end
         // unused key field carries noise now and then
         if (op != OP_APPEND && $urandom_range(0, 1) == 1) key = 4'($urandom);
         offer(op, key, val, 1'b0, NO_CHECK);
      end
      burst = 1'b0;
      req_valid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d from the table), %0d responses compared, %0d refused",
               requests_sent, TABLE_ROWS, responses_checked, flashes_seen);
      $display("Mix: append %0d, delete %0d, clear %0d, set %0d, error %0d, unused %0d",
               op_seen[OP_APPEND], op_seen[OP_DELETE], op_seen[OP_CLEAR], op_seen[OP_SET],
               op_seen[OP_ERROR],
               op_seen[OP_UNUSED_LO] + op_seen[OP_UNUSED_MID] + op_seen[OP_UNUSED_HI]);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
